// ===== hw/rtl/mrul_pkg.sv =====
package mrul_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ID_W       = 8;
    localparam int IDLE_W     = 16;

    localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd300;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_SWITCH = 3'd1,
        ACT_NEXT   = 3'd2,
        ACT_PREV   = 3'd3,
        ACT_SELECT = 3'd4
    } action_t;

    // result word, listed from the highest bit down
    typedef struct packed {
        logic [7:0] current_id;
        logic [4:0] entry_count;
        logic [3:0] cursor_pos;
        logic       is_cycling;
        logic [7:0] jump_target;
    } out_word_t;

endpackage

// ===== hw/rtl/mru_list_cycle_selector_core.sv =====
// most-recently-used id list with a cycling cursor
//
// input words arrive on s_axis_*: tuser carries the command (tick, switch,
// next, prev, select), tdata the ids left and entered on a switch. every
// accepted word gives exactly one result word on m_axis_*, with tuser set
// when the command (or an idle timeout during a tick) selected a jump target.
// the idle timeout register is written through cfg_valid/cfg_ready/cfg_data
// (cfg_ready is always high); the user must write it only while no command
// is in flight, as the block itself does not enforce this.
// the list lives in a single-port-read, single-port-write memory of
// LIST_DEPTH ids. tick, next and prev go from accept straight to the
// finish state, but a tick that times out under a valid cursor runs a
// selection. a switch or a selection runs up to two search-and-shift
// passes over the list of at most 16 ids, reading the memory one entry
// at a time. one word is worked on at a time; the next word is taken once the
// current one has reached the output register, even while the receiver
// stalls that result.
// reset empties the list, clears the current id and cursor and loads the
// timeout with 300. no memory clearing pass is needed.
module mru_list_cycle_selector_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // old_id, new_id
    input  logic [2:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // jump_target, is_cycling, cursor_pos, entry_count, current_id
    output logic        m_axis_tuser,  // jump_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import mrul_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAKE,
        ST_DISPATCH,
        ST_SEARCH,
        ST_INSERT,
        ST_REMOVE,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [ID_W-1:0]   cur_reg, cur_next;
    logic              cyc_reg, cyc_next;
    logic [IDX_W-1:0]  cursor_reg, cursor_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic [IDLE_W-1:0] timeout_reg, timeout_next;
    logic [ID_W-1:0]   target_reg, target_next;
    logic              push_pend_reg, push_pend_next;
    logic [ID_W-1:0]   push_id_reg, push_id_next;
    logic              drop_pend_reg, drop_pend_next;
    logic [ID_W-1:0]   drop_id_reg, drop_id_next;
    logic [ID_W-1:0]   op_id_reg, op_id_next;
    logic              ins_mode_reg, ins_mode_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              rd_pend_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              m_valid_reg, m_valid_next;
    logic              m_jump_reg, m_jump_next;
    out_word_t         m_word_reg, m_word_next;

    logic [ID_W-1:0]   mem [LIST_DEPTH];
    logic [ID_W-1:0]   rd_data_reg;
    logic              mem_re, mem_we;
    logic [IDX_W-1:0]  mem_ra, mem_wa;
    logic [ID_W-1:0]   mem_wd;

    action_t           act;
    logic [ID_W-1:0]   in_old, in_new;
    logic [IDLE_W-1:0] idle_inc, eff_timeout;
    logic              cursor_ok, match;

    assign act    = action_t'(s_axis_tuser);
    assign in_old = s_axis_tdata[7:0];
    assign in_new = s_axis_tdata[15:8];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_jump_reg;
    assign m_axis_tdata  = {6'd0, m_word_reg};

    assign idle_inc    = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;
    assign eff_timeout = (timeout_reg == '0) ? IDLE_W'(1) : timeout_reg;
    assign cursor_ok   = cyc_reg && (CNT_W'(cursor_reg) < fill_reg);
    assign match       = rd_pend_reg && (rd_data_reg == op_id_reg);

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cur_next       = cur_reg;
        cyc_next       = cyc_reg;
        cursor_next    = cursor_reg;
        idle_next      = idle_reg;
        timeout_next   = timeout_reg;
        target_next    = target_reg;
        push_pend_next = push_pend_reg;
        push_id_next   = push_id_reg;
        drop_pend_next = drop_pend_reg;
        drop_id_next   = drop_id_reg;
        op_id_next     = op_id_reg;
        ins_mode_next  = ins_mode_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_jump_next    = m_jump_reg;
        m_word_next    = m_word_reg;
        mem_re         = 1'b0;
        mem_ra         = cursor_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = rd_data_reg;

        if (cfg_valid) begin
            timeout_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    target_next = '0;
                    state_next  = ST_FINISH;
                    unique case (act)
                        ACT_TICK: begin
                            if (idle_inc >= eff_timeout) begin
                                idle_next = '0;
                                if (cursor_ok) begin
                                    mem_re     = 1'b1;
                                    state_next = ST_TAKE;
                                end
                            end else begin
                                idle_next = idle_inc;
                            end
                        end
                        ACT_SWITCH: begin
                            idle_next      = '0;
                            push_pend_next = (in_old != '0) && (in_old != in_new);
                            push_id_next   = in_old;
                            drop_pend_next = (in_new != '0);
                            drop_id_next   = in_new;
                            if (in_new != '0) begin
                                cur_next = in_new;
                            end
                            cyc_next    = 1'b0;
                            cursor_next = '0;
                            state_next  = ST_DISPATCH;
                        end
                        ACT_NEXT: begin
                            idle_next = '0;
                            if (fill_reg != '0) begin
                                cyc_next = 1'b1;
                                if (!cyc_reg || (CNT_W'(cursor_reg) + 1'b1 == fill_reg)) begin
                                    cursor_next = '0;
                                end else begin
                                    cursor_next = cursor_reg + 1'b1;
                                end
                            end
                        end
                        ACT_PREV: begin
                            idle_next = '0;
                            if (fill_reg != '0) begin
                                cyc_next = 1'b1;
                                if (!cyc_reg || (cursor_reg == '0)) begin
                                    cursor_next = IDX_W'(fill_reg - 1'b1);
                                end else begin
                                    cursor_next = cursor_reg - 1'b1;
                                end
                            end
                        end
                        ACT_SELECT: begin
                            idle_next = '0;
                            if (cursor_ok) begin
                                mem_re     = 1'b1;
                                state_next = ST_TAKE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TAKE: begin
                target_next    = rd_data_reg;
                push_pend_next = (cur_reg != '0) && (cur_reg != rd_data_reg);
                push_id_next   = cur_reg;
                drop_pend_next = 1'b0;
                cur_next       = rd_data_reg;
                cyc_next       = 1'b0;
                cursor_next    = '0;
                pos_next       = CNT_W'(cursor_reg) + 1'b1;
                state_next     = ST_REMOVE;
            end
            ST_DISPATCH: begin
                pos_next = '0;
                if (push_pend_reg) begin
                    op_id_next     = push_id_reg;
                    ins_mode_next  = 1'b1;
                    push_pend_next = 1'b0;
                    state_next     = ST_SEARCH;
                end else if (drop_pend_reg) begin
                    op_id_next     = drop_id_reg;
                    ins_mode_next  = 1'b0;
                    drop_pend_next = 1'b0;
                    state_next     = ST_SEARCH;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SEARCH: begin
                if (match) begin
                    found_next = 1'b1;
                    if (ins_mode_reg) begin
                        pos_next   = CNT_W'(rd_idx_reg);
                        state_next = ST_INSERT;
                    end else begin
                        pos_next   = CNT_W'(rd_idx_reg) + 1'b1;
                        state_next = ST_REMOVE;
                    end
                end else if (pos_reg < fill_reg) begin
                    mem_re   = 1'b1;
                    mem_ra   = pos_reg[IDX_W-1:0];
                    pos_next = pos_reg + 1'b1;
                end else if (!rd_pend_reg) begin
                    found_next = 1'b0;
                    if (ins_mode_reg) begin
                        pos_next   = (fill_reg == DEPTH_C) ? DEPTH_C - 1'b1 : fill_reg;
                        state_next = ST_INSERT;
                    end else begin
                        state_next = ST_DISPATCH;
                    end
                end
            end
            ST_INSERT: begin
                // shift toward the back, then the id goes in front
                if (rd_pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = rd_idx_reg + 1'b1;
                end
                if (pos_reg != '0) begin
                    mem_re   = 1'b1;
                    mem_ra   = IDX_W'(pos_reg - 1'b1);
                    pos_next = pos_reg - 1'b1;
                end else if (!rd_pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = '0;
                    mem_wd = op_id_reg;
                    if (!found_reg && (fill_reg != DEPTH_C)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = ST_DISPATCH;
                end
            end
            ST_REMOVE: begin
                // close the gap by shifting toward the front
                if (rd_pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = rd_idx_reg - 1'b1;
                end
                if (pos_reg < fill_reg) begin
                    mem_re   = 1'b1;
                    mem_ra   = pos_reg[IDX_W-1:0];
                    pos_next = pos_reg + 1'b1;
                end else if (!rd_pend_reg) begin
                    fill_next  = fill_reg - 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next            = 1'b1;
                    m_jump_next             = (target_reg != '0);
                    m_word_next.jump_target = target_reg;
                    m_word_next.is_cycling  = cyc_reg;
                    m_word_next.cursor_pos  = 4'(cursor_reg);
                    m_word_next.entry_count = 5'(fill_reg);
                    m_word_next.current_id  = cur_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cur_reg       <= '0;
            cyc_reg       <= 1'b0;
            cursor_reg    <= '0;
            idle_reg      <= '0;
            timeout_reg   <= IDLE_RESET;
            push_pend_reg <= 1'b0;
            drop_pend_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cur_reg       <= cur_next;
            cyc_reg       <= cyc_next;
            cursor_reg    <= cursor_next;
            idle_reg      <= idle_next;
            timeout_reg   <= timeout_next;
            push_pend_reg <= push_pend_next;
            drop_pend_reg <= drop_pend_next;
            rd_pend_reg   <= mem_re;
            m_valid_reg   <= m_valid_next;
        end
        target_reg   <= target_next;
        push_id_reg  <= push_id_next;
        drop_id_reg  <= drop_id_next;
        op_id_reg    <= op_id_next;
        ins_mode_reg <= ins_mode_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        rd_idx_reg   <= mem_ra;
        m_jump_reg   <= m_jump_next;
        m_word_reg   <= m_word_next;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_C)
        else $error("list fill above depth");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cyc_reg |-> (CNT_W'(cursor_reg) < fill_reg))
        else $error("cycle cursor outside list");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("list write while idle");

    a_jump_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_jump_reg) |-> (m_word_reg.jump_target != '0))
        else $error("jump to empty id");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrul_pkg::*;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam logic [2:0]  ACT_RSVD_5  = 3'd5;
    localparam logic [2:0]  ACT_RSVD_6  = 3'd6;
    localparam logic [2:0]  ACT_RSVD_7  = 3'd7;
    localparam int          NUM_PHASES  = 6;

    typedef struct packed {
        logic       jump_valid;
        out_word_t  w;
    } sel_word_t;

    typedef struct {
        logic [2:0] act;
        logic [7:0] old_id;
        logic [7:0] new_id;
        bit         typed;
        sel_word_t  want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // old_id, new_id
    logic [2:0]  s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // jump_target, is_cycling, cursor_pos, entry_count, current_id
    logic        m_axis_tuser;   // jump_valid
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    mru_list_cycle_selector_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // predictor state
    logic [7:0]  mru_ids [LIST_DEPTH];
    int unsigned mru_fill;
    logic [7:0]  cur_id;
    bit          cycling;
    int unsigned cursor_at;
    int unsigned idle_n;
    logic [15:0] idle_limit;

    sel_word_t   due_selector_words [$];
    int          err_n;
    int          cycle_n;
    int          burst_left;
    int          hold_n;
    bit          pin_typed;
    sel_word_t   pin_word;
    dir_row_t    dir_rows [$];

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic void list_remove_at(int unsigned pos);
        if (pos >= mru_fill) return;
        for (int unsigned k = pos; k + 1 < mru_fill; k++) mru_ids[k] = mru_ids[k + 1];
        mru_fill--;
    endfunction

    function automatic void list_remove_id(logic [7:0] id);
        for (int unsigned k = 0; k < mru_fill; k++) begin
            if (mru_ids[k] == id) begin
                list_remove_at(k);
                return;
            end
        end
    endfunction

    function automatic void list_push_front(logic [7:0] id);
        list_remove_id(id);
        if (mru_fill >= LIST_DEPTH) mru_fill = LIST_DEPTH - 1;
        for (int unsigned k = mru_fill; k > 0; k--) mru_ids[k] = mru_ids[k - 1];
        mru_ids[0] = id;
        mru_fill++;
    endfunction

    function automatic logic [7:0] take_under_cursor();
        logic [7:0] target;
        if (!cycling || cursor_at >= mru_fill) return 8'd0;
        target = mru_ids[cursor_at];
        list_remove_at(cursor_at);
        if (cur_id != 8'd0 && cur_id != target) list_push_front(cur_id);
        cur_id    = target;
        cycling   = 1'b0;
        cursor_at = 0;
        return target;
    endfunction

    function automatic sel_word_t predict_selector_state(logic [2:0] act, logic [7:0] old_id,
                                                         logic [7:0] new_id);
        logic [7:0] target;
        sel_word_t  r;
        target = 8'd0;
        if (act >= ACT_SWITCH && act <= ACT_SELECT) idle_n = 0;
        case (act)
            ACT_TICK: begin
                if (idle_n < 32'hFFFF) idle_n++;
                if (idle_n >= idle_limit) begin
                    idle_n = 0;
                    target = take_under_cursor();
                end
            end
            ACT_SWITCH: begin
                if (old_id != 8'd0 && old_id != new_id) list_push_front(old_id);
                if (new_id != 8'd0) begin
                    cur_id = new_id;
                    list_remove_id(new_id);
                end
                cycling   = 1'b0;
                cursor_at = 0;
            end
            ACT_NEXT: begin
                if (mru_fill != 0) begin
                    if (!cycling) begin
                        cycling   = 1'b1;
                        cursor_at = 0;
                    end else begin
                        cursor_at = (cursor_at + 1) % mru_fill;
                    end
                end
            end
            ACT_PREV: begin
                if (mru_fill != 0) begin
                    if (!cycling) begin
                        cycling   = 1'b1;
                        cursor_at = mru_fill - 1;
                    end else begin
                        cursor_at = (cursor_at % mru_fill + mru_fill - 1) % mru_fill;
                    end
                end
            end
            ACT_SELECT: target = take_under_cursor();
            default: ;
        endcase
        r.jump_valid    = (target != 8'd0);
        r.w.jump_target = target;
        r.w.is_cycling  = cycling;
        r.w.cursor_pos  = cursor_at[3:0];
        r.w.entry_count = mru_fill[4:0];
        r.w.current_id  = cur_id;
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        err_n++;
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // monitor: config, accepted words and result words at the rising edge
    always @(posedge aclk) begin
        sel_word_t  want;
        sel_word_t  pred;
        out_word_t  got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) idle_limit = cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                pred = predict_selector_state(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
                due_selector_words.push_back(pin_typed ? pin_word : pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_selector_words.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = due_selector_words.pop_front();
                    got  = out_word_t'(m_axis_tdata[$bits(out_word_t)-1:0]);
                    if (m_axis_tuser !== want.jump_valid)
                        report_mismatch("jump_valid", m_axis_tuser, want.jump_valid);
                    if (got.jump_target !== want.w.jump_target)
                        report_mismatch("jump_target", got.jump_target, want.w.jump_target);
                    if (got.is_cycling !== want.w.is_cycling)
                        report_mismatch("is_cycling", got.is_cycling, want.w.is_cycling);
                    if (got.cursor_pos !== want.w.cursor_pos)
                        report_mismatch("cursor_pos", got.cursor_pos, want.w.cursor_pos);
                    if (got.entry_count !== want.w.entry_count)
                        report_mismatch("entry_count", got.entry_count, want.w.entry_count);
                    if (got.current_id !== want.w.current_id)
                        report_mismatch("current_id", got.current_id, want.w.current_id);
                    if (m_axis_tdata[31:$bits(out_word_t)] !== '0)
                        report_mismatch("tdata padding", m_axis_tdata[31:$bits(out_word_t)], 0);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern, chosen by bits 9:8 of the cycle counter
    always @(negedge aclk) begin
        case (cycle_n[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2'd2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: begin
                if (hold_n != 0) begin
                    hold_n--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0) hold_n = $urandom_range(5, 40);
                end
            end
        endcase
    end

    // called and returns at a falling edge; valid stays high for a following word
    task automatic send_word(logic [2:0] act, logic [7:0] old_id, logic [7:0] new_id,
                             bit typed = 1'b0, sel_word_t want = '0);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {new_id, old_id};
        s_axis_tuser  <= act;
        pin_typed     <= typed;
        pin_word      <= want;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (due_selector_words.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_idle_limit(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'd0;
        if (r < 20) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, 20));
    endfunction

    task automatic send_ticks(output int n);
        int top;
        top = (idle_limit + 1 > 24) ? 24 : idle_limit + 1;
        n = $urandom_range(1, top);
        repeat (n) send_word(ACT_TICK, pick_id(), pick_id());
    endtask

    task automatic run_random(int n_words);
        int sent;
        int r;
        int k;
        int t;
        sent = 0;
        while (sent < n_words) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_word(ACT_SWITCH, pick_id(), pick_id());
                sent++;
            end else if (r < 75) begin
                k = $urandom_range(1, 4);
                repeat (k) send_word(($urandom_range(0, 1) == 0) ? ACT_NEXT : ACT_PREV,
                                     pick_id(), pick_id());
                sent += k;
                case ($urandom_range(0, 3))
                    0, 1: begin
                        send_word(ACT_SELECT, pick_id(), pick_id());
                        sent++;
                    end
                    2: begin
                        send_ticks(t);
                        sent += t;
                    end
                    default: begin
                        send_word(ACT_SWITCH, pick_id(), pick_id());
                        sent++;
                    end
                endcase
            end else if (r < 90) begin
                send_ticks(t);
                sent += t;
            end else begin
                send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    function automatic dir_row_t row(logic [2:0] act, logic [7:0] old_id, logic [7:0] new_id,
                                     bit typed, bit jv, logic [7:0] tgt, bit cyc,
                                     logic [3:0] pos, logic [4:0] cnt, logic [7:0] id);
        dir_row_t d;
        d.act                = act;
        d.old_id             = old_id;
        d.new_id             = new_id;
        d.typed              = typed;
        d.want.jump_valid    = jv;
        d.want.w.jump_target = tgt;
        d.want.w.is_cycling  = cyc;
        d.want.w.cursor_pos  = pos;
        d.want.w.entry_count = cnt;
        d.want.w.current_id  = id;
        return d;
    endfunction

    initial begin
        logic [15:0] phase_limit [NUM_PHASES] = '{16'd1, 16'd65535, 16'd2, 16'd5, 16'd12, 16'd3};
        int          phase_words [NUM_PHASES] = '{200, 150, 200, 200, 150, 130};

        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_TICK;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        pin_typed     = 1'b0;
        pin_word      = '0;
        err_n         = 0;
        cycle_n       = 0;
        burst_left    = 0;
        hold_n        = 0;
        foreach (mru_ids[i]) mru_ids[i] = '0;
        mru_fill   = 0;
        cur_id     = '0;
        cycling    = 1'b0;
        cursor_at  = 0;
        idle_n     = 0;
        idle_limit = IDLE_RESET;

        //                act          old   new  typed jv tgt  cyc pos cnt id
        dir_rows.push_back(row(ACT_TICK,   8'd0,   8'd0,   1, 0, 8'd0, 0, 0, 0, 8'd0));
        dir_rows.push_back(row(ACT_NEXT,   8'd0,   8'd0,   1, 0, 8'd0, 0, 0, 0, 8'd0));
        dir_rows.push_back(row(ACT_PREV,   8'd0,   8'd0,   1, 0, 8'd0, 0, 0, 0, 8'd0));
        dir_rows.push_back(row(ACT_SELECT, 8'd0,   8'd0,   1, 0, 8'd0, 0, 0, 0, 8'd0));
        dir_rows.push_back(row(ACT_SWITCH, 8'd0,   8'd1,   1, 0, 8'd0, 0, 0, 0, 8'd1));
        dir_rows.push_back(row(ACT_SWITCH, 8'd1,   8'd2,   1, 0, 8'd0, 0, 0, 1, 8'd2));
        dir_rows.push_back(row(ACT_SWITCH, 8'd2,   8'd2,   1, 0, 8'd0, 0, 0, 1, 8'd2));
        // empty new id keeps the current id while the old one is pushed
        dir_rows.push_back(row(ACT_SWITCH, 8'd2,   8'd0,   1, 0, 8'd0, 0, 0, 2, 8'd2));
        dir_rows.push_back(row(ACT_SWITCH, 8'd255, 8'd128, 1, 0, 8'd0, 0, 0, 3, 8'd128));
        dir_rows.push_back(row(ACT_NEXT,   8'd0,   8'd0,   1, 0, 8'd0, 1, 0, 3, 8'd128));
        dir_rows.push_back(row(ACT_NEXT,   8'd0,   8'd0,   0, 0, 8'd0, 0, 0, 0, 8'd0));
        dir_rows.push_back(row(ACT_PREV,   8'd0,   8'd0,   0, 0, 8'd0, 0, 0, 0, 8'd0));
        dir_rows.push_back(row(ACT_PREV,   8'd0,   8'd0,   0, 0, 8'd0, 0, 0, 0, 8'd0));
        dir_rows.push_back(row(ACT_SELECT, 8'd0,   8'd0,   1, 1, 8'd1, 0, 0, 3, 8'd1));
        dir_rows.push_back(row(ACT_PREV,   8'd0,   8'd0,   1, 0, 8'd0, 1, 2, 3, 8'd1));
        dir_rows.push_back(row(ACT_RSVD_7, 8'd255, 8'd255, 1, 0, 8'd0, 1, 2, 3, 8'd1));
        dir_rows.push_back(row(ACT_SELECT, 8'd0,   8'd0,   1, 1, 8'd2, 0, 0, 3, 8'd2));
        dir_rows.push_back(row(ACT_NEXT,   8'd0,   8'd0,   1, 0, 8'd0, 1, 0, 3, 8'd2));
        // switch to nothing still ends cycling
        dir_rows.push_back(row(ACT_SWITCH, 8'd0,   8'd0,   1, 0, 8'd0, 0, 0, 3, 8'd2));
        dir_rows.push_back(row(ACT_RSVD_5, 8'd0,   8'd0,   1, 0, 8'd0, 0, 0, 3, 8'd2));
        dir_rows.push_back(row(ACT_RSVD_6, 8'd170, 8'd85,  1, 0, 8'd0, 0, 0, 3, 8'd2));
        dir_rows.push_back(row(ACT_TICK,   8'd255, 8'd255, 0, 0, 8'd0, 0, 0, 0, 8'd0));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].act, dir_rows[i].old_id, dir_rows[i].new_id,
                      dir_rows[i].typed, dir_rows[i].want);
        run_random(250);
        drain_results();
        run_random(150);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_idle_limit(phase_limit[p]);
            run_random(phase_words[p]);
        end

        s_axis_tvalid <= 1'b0;
        while (due_selector_words.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (due_selector_words.size() != 0)
            report_mismatch("missing words", due_selector_words.size(), 0);
        if (err_n == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
